// ----- sv/cas_pkg.sv -----
// cas_pkg: shared types, constants and the energy table for channel_airtime_survey.
// No dependencies.
`default_nettype none
package cas_pkg;

    localparam int CHANNELS_DEF = 13;
    localparam int NODES_DEF    = 8;

    localparam logic [31:0] SCORE_CAP = 32'd4000000000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam int          ROM_SIZE  = 97;

    // action codes
    typedef enum logic [2:0] {
        ACT_FRAME  = 3'd0,
        ACT_TUNE   = 3'd1,
        ACT_CLEAR  = 3'd2,
        ACT_CHOOSE = 3'd3,
        ACT_REPORT = 3'd4,
        ACT_NODE   = 3'd5,
        ACT_NOP6   = 3'd6,
        ACT_NOP7   = 3'd7
    } t_action;

    // classified item passed from front to back
    typedef struct packed {
        t_action     action;
        logic signed [7:0] rssi;
        logic        own_node;
        logic [3:0]  channel;
    } t_cmd;

    // floor(10^(k/10)) for k = rssi + 100; 0 for k < 0, SCORE_CAP for k >= 97
    function automatic logic [31:0] energy_term(input logic signed [7:0] rssi);
        logic signed [8:0] k;
        logic [31:0] v;
        k = 9'(rssi) + 9'sd100;
        v = 32'd0;
        if (k < 0) begin
            v = 32'd0;
        end else if (k >= 9'sd97) begin
            v = SCORE_CAP;
        end else begin
            case (k[6:0])
                7'd0: v = 1; 7'd1: v = 1; 7'd2: v = 1; 7'd3: v = 1; 7'd4: v = 2;
                7'd5: v = 3; 7'd6: v = 3; 7'd7: v = 5; 7'd8: v = 6; 7'd9: v = 7;
                7'd10: v = 10; 7'd11: v = 12; 7'd12: v = 15; 7'd13: v = 19;
                7'd14: v = 25; 7'd15: v = 31; 7'd16: v = 39; 7'd17: v = 50;
                7'd18: v = 63; 7'd19: v = 79; 7'd20: v = 100; 7'd21: v = 125;
                7'd22: v = 158; 7'd23: v = 199; 7'd24: v = 251; 7'd25: v = 316;
                7'd26: v = 398; 7'd27: v = 501; 7'd28: v = 630; 7'd29: v = 794;
                7'd30: v = 1000; 7'd31: v = 1258; 7'd32: v = 1584; 7'd33: v = 1995;
                7'd34: v = 2511; 7'd35: v = 3162; 7'd36: v = 3981; 7'd37: v = 5011;
                7'd38: v = 6309; 7'd39: v = 7943; 7'd40: v = 10000; 7'd41: v = 12589;
                7'd42: v = 15848; 7'd43: v = 19952; 7'd44: v = 25118; 7'd45: v = 31622;
                7'd46: v = 39810; 7'd47: v = 50118; 7'd48: v = 63095; 7'd49: v = 79432;
                7'd50: v = 100000; 7'd51: v = 125892; 7'd52: v = 158489;
                7'd53: v = 199526; 7'd54: v = 251188; 7'd55: v = 316227;
                7'd56: v = 398107; 7'd57: v = 501187; 7'd58: v = 630957;
                7'd59: v = 794328; 7'd60: v = 1000000; 7'd61: v = 1258925;
                7'd62: v = 1584893; 7'd63: v = 1995262; 7'd64: v = 2511886;
                7'd65: v = 3162277; 7'd66: v = 3981071; 7'd67: v = 5011872;
                7'd68: v = 6309573; 7'd69: v = 7943282; 7'd70: v = 10000000;
                7'd71: v = 12589254; 7'd72: v = 15848931; 7'd73: v = 19952623;
                7'd74: v = 25118864; 7'd75: v = 31622776; 7'd76: v = 39810717;
                7'd77: v = 50118723; 7'd78: v = 63095734; 7'd79: v = 79432823;
                7'd80: v = 100000000; 7'd81: v = 125892541; 7'd82: v = 158489319;
                7'd83: v = 199526231; 7'd84: v = 251188643; 7'd85: v = 316227766;
                7'd86: v = 398107170; 7'd87: v = 501187233; 7'd88: v = 630957344;
                7'd89: v = 794328234; 7'd90: v = 1000000000; 7'd91: v = 1258925411;
                7'd92: v = 1584893192; 7'd93: v = 1995262314; 7'd94: v = 32'd2511886431;
                7'd95: v = 32'd3162277660; 7'd96: v = 32'd3981071705;
                default: v = 32'd0;
            endcase
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- sv/cas_front.sv -----
// cas_front: accepts items, keeps the node table, flags own-node frames.
// Depends on cas_pkg.
`default_nettype none
module cas_front #(
    parameter int NODES = cas_pkg::NODES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_action,
    input  wire logic signed [7:0]  i_rssi,
    input  wire logic               i_has_tx_addr,
    input  wire logic [47:0]        i_tx_addr,
    input  wire logic [3:0]         i_channel,
    input  wire logic [2:0]         i_node_slot,
    input  wire logic [47:0]        i_node_address,
    input  wire logic               i_node_in_use,
    output logic                    o_cmd_valid,
    input  wire logic               i_cmd_ready,
    output cas_pkg::t_cmd           o_cmd
);

    localparam int SLOT_W = (NODES > 1) ? $clog2(NODES) : 1;

    logic [47:0]      r_node_addr [NODES];
    logic [NODES-1:0] r_node_vld;
    logic [NODES-1:0] w_hit;
    logic             w_acc;

    // one-entry stage toward the back queue
    assign o_ready = !o_cmd_valid || i_cmd_ready;
    assign w_acc   = i_valid && o_ready;

    // address match against each valid entry
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            w_hit[i] = r_node_vld[i] && (r_node_addr[i] == i_tx_addr);
        end
    end

    // node table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_vld <= '0;
        end else if (w_acc && i_action == cas_pkg::ACT_NODE
                     && 32'(i_node_slot) < NODES) begin
            r_node_vld[SLOT_W'(i_node_slot)] <= i_node_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_action == cas_pkg::ACT_NODE && 32'(i_node_slot) < NODES) begin
            r_node_addr[SLOT_W'(i_node_slot)] <= i_node_address;
        end
    end

    // classified item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_cmd_valid <= 1'b0;
        end else if (o_ready) begin
            o_cmd_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            o_cmd.action   <= cas_pkg::t_action'(i_action);
            o_cmd.rssi     <= i_rssi;
            o_cmd.own_node <= i_has_tx_addr && (|w_hit);
            o_cmd.channel  <= i_channel;
        end
    end

endmodule
`default_nettype wire

// ----- sv/cas_queue.sv -----
// cas_queue: two-entry queue between front and back.
// Depends on cas_pkg.
`default_nettype none
module cas_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire cas_pkg::t_cmd i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output cas_pkg::t_cmd      o_data
);

    cas_pkg::t_cmd r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop) else $error("pop from empty queue");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> r_cnt == 2'd2) else $error("full queue lost entry");
`endif

endmodule
`default_nettype wire

// ----- sv/cas_back.sv -----
// cas_back: executes items on the per-channel statistics, builds results.
// Depends on cas_pkg.
`default_nettype none
module cas_back #(
    parameter int CHANNELS = cas_pkg::CHANNELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_ready,
    input  wire cas_pkg::t_cmd      i_cmd,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [3:0]              o_chosen_channel,
    output logic [15:0]             o_frame_count,
    output logic signed [7:0]       o_strongest_rssi,
    output logic [31:0]             o_energy_score
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_WRITE, ST_SCAN, ST_EMIT, ST_CLEAR
    } t_state;

    t_state             r_state;
    cas_pkg::t_cmd      r_cmd;
    logic [3:0]         r_tuned;
    logic [CHANNELS:1]  r_vld;     // entry not valid reads as zero
    logic [15:0]        r_cnt   [CHANNELS+1];
    logic signed [7:0]  r_peak  [CHANNELS+1];
    logic [31:0]        r_score [CHANNELS+1];
    logic [3:0]         r_ch, r_best;
    logic [4:0]         r_scan;    // one bit wider so the walk ends past channel 15
    logic [31:0]        r_best_score;
    logic [15:0]        r_rd_cnt;
    logic signed [7:0]  r_rd_peak;
    logic [31:0]        r_rd_score;
    logic [31:0]        r_term;

    logic [15:0]        w_new_cnt;
    logic               w_in_range;

    assign o_cmd_ready = (r_state == ST_IDLE) && !o_valid;
    assign w_in_range  = (r_ch != 4'd0) && (32'(r_ch) <= CHANNELS);
    assign w_new_cnt   = (r_rd_cnt == cas_pkg::COUNT_MAX) ? r_rd_cnt : r_rd_cnt + 16'd1;

    // control sequencer, one item at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tuned <= 4'd0;
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.action)
                            cas_pkg::ACT_FRAME: begin
                                r_ch <= r_tuned;
                                if (r_tuned != 4'd0 && 32'(r_tuned) <= CHANNELS
                                    && !i_cmd.own_node) r_state <= ST_READ;
                            end
                            cas_pkg::ACT_TUNE:  r_tuned <= i_cmd.channel;
                            cas_pkg::ACT_CLEAR: r_state <= ST_CLEAR;
                            cas_pkg::ACT_CHOOSE: begin
                                r_best       <= 4'd1;
                                r_scan       <= 5'd2;
                                r_best_score <= r_vld[1] ? r_score[1] : 32'd0;
                                r_state      <= ST_SCAN;
                            end
                            cas_pkg::ACT_REPORT: begin
                                r_ch    <= i_cmd.channel;
                                r_state <= ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    r_rd_cnt   <= (w_in_range && r_vld[r_ch]) ? r_cnt[r_ch]   : 16'd0;
                    r_rd_peak  <= (w_in_range && r_vld[r_ch]) ? r_peak[r_ch]  : 8'sd0;
                    r_rd_score <= (w_in_range && r_vld[r_ch]) ? r_score[r_ch] : 32'd0;
                    r_term     <= cas_pkg::energy_term(r_cmd.rssi);
                    r_state    <= (r_cmd.action == cas_pkg::ACT_FRAME) ? ST_WRITE : ST_EMIT;
                end
                ST_WRITE: begin
                    r_vld[r_ch] <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (32'(r_scan) > CHANNELS) begin
                        r_ch    <= r_best;
                        r_state <= ST_READ;
                    end else begin
                        if ((r_vld[r_scan[3:0]] ? r_score[r_scan[3:0]] : 32'd0)
                            < r_best_score) begin
                            r_best       <= r_scan[3:0];
                            r_best_score <= r_vld[r_scan[3:0]] ? r_score[r_scan[3:0]]
                                                               : 32'd0;
                        end
                        r_scan <= r_scan + 5'd1;
                    end
                end
                ST_EMIT: begin
                    o_valid          <= 1'b1;
                    o_chosen_channel <= r_ch;
                    o_frame_count    <= r_rd_cnt;
                    o_strongest_rssi <= (r_rd_cnt != 16'd0) ? r_rd_peak : 8'sd0;
                    o_energy_score   <= r_rd_score;
                    r_state          <= ST_IDLE;
                end
                ST_CLEAR: begin
                    r_vld   <= '0;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // statistics write-back
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_cnt[r_ch] <= w_new_cnt;
            if (w_new_cnt == 16'd1 || r_cmd.rssi > r_rd_peak) r_peak[r_ch] <= r_cmd.rssi;
            if (r_rd_score < cas_pkg::SCORE_CAP - r_term)
                r_score[r_ch] <= r_rd_score + r_term;
            else
                r_score[r_ch] <= r_rd_score;
        end
    end

`ifndef SYNTH
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd_ready) else $error("ready while busy");
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |=> o_valid) else $error("result not raised");
    a_score_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_energy_score <= cas_pkg::SCORE_CAP) else $error("score above cap");
`endif

endmodule
`default_nettype wire

// ----- sv/channel_airtime_survey.sv -----
// channel_airtime_survey: top level, front classifier, queue and back executor.
// Depends on cas_pkg, cas_front, cas_queue, cas_back.
//
//  channel | handshake            | payload
//  input   | i_valid / o_ready    | i_action .. i_node_in_use
//  result  | o_valid / i_ready    | o_chosen_channel .. o_energy_score
//
// Frame: in the back through idle, read, write; report: idle, read, emit.
// Choose walks the channels one a cycle, then reads and emits the best.
// Clear: idle, clear; statistics reset through per-channel valid bits.
// Reset is synchronous; the back waits until a pending result is taken.
`default_nettype none
module channel_airtime_survey #(
    parameter int CHANNELS = cas_pkg::CHANNELS_DEF,
    parameter int NODES    = cas_pkg::NODES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_action,
    input  wire logic signed [7:0]  i_rssi,
    input  wire logic               i_has_tx_addr,
    input  wire logic [47:0]        i_tx_addr,
    input  wire logic [3:0]         i_channel,
    input  wire logic [2:0]         i_node_slot,
    input  wire logic [47:0]        i_node_address,
    input  wire logic               i_node_in_use,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [3:0]              o_chosen_channel,
    output logic [15:0]             o_frame_count,
    output logic signed [7:0]       o_strongest_rssi,
    output logic [31:0]             o_energy_score
);

    logic          w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    cas_pkg::t_cmd w_f_cmd, w_q_cmd;

    cas_front #(.NODES(NODES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_action, .i_rssi, .i_has_tx_addr, .i_tx_addr, .i_channel,
        .i_node_slot, .i_node_address, .i_node_in_use,
        .o_cmd_valid(w_f_valid), .i_cmd_ready(w_f_ready), .o_cmd(w_f_cmd)
    );

    cas_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_f_valid), .o_ready(w_f_ready), .i_data(w_f_cmd),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_data(w_q_cmd)
    );

    cas_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_q_valid), .o_cmd_ready(w_q_ready), .i_cmd(w_q_cmd),
        .o_valid, .i_ready, .o_chosen_channel, .o_frame_count,
        .o_strongest_rssi, .o_energy_score
    );

endmodule
`default_nettype wire

// ----- test/channel_airtime_survey_tb.sv -----
// channel_airtime_survey_tb: self-checking bench for the per-channel airtime statistics block.
// Depends on cas_pkg and channel_airtime_survey; a built-in predictor checks every result.
`default_nettype none
module channel_airtime_survey_tb;
    import cas_pkg::*;

    localparam int NCH   = 13;
    localparam int NSLOT = 8;
    localparam int RANDOM_ITEMS = 1230;

    typedef struct packed {
        logic [3:0]        ch;
        logic [15:0]       cnt;
        logic signed [7:0] pk;
        logic [31:0]       sc;
    } t_stats;

    typedef struct {
        t_action           act;
        logic signed [7:0] rssi;
        logic              has;
        logic [47:0]       tx;
        logic [3:0]        ch;
        logic [2:0]        slot;
        logic [47:0]       addr;
        logic              use_it;
        logic              pinned;
        t_stats            res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_action = ACT_NOP6;
    logic signed [7:0]  i_rssi = '0;
    logic               i_has_tx_addr = 1'b0;
    logic [47:0]        i_tx_addr = '0;
    logic [3:0]         i_channel = '0;
    logic [2:0]         i_node_slot = '0;
    logic [47:0]        i_node_address = '0;
    logic               i_node_in_use = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [3:0]         o_chosen_channel;
    logic [15:0]        o_frame_count;
    logic signed [7:0]  o_strongest_rssi;
    logic [31:0]        o_energy_score;

    channel_airtime_survey DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [3:0]        tuned;
    logic [15:0]       counts [1:NCH];
    logic signed [7:0] peaks  [1:NCH];
    logic [31:0]       scores [1:NCH];
    logic [47:0]       node_addr [NSLOT];
    logic              node_ok   [NSLOT];

    t_stats stats_due[$];
    t_stats pin_res;
    logic   pin_on = 1'b0;
    int     errors = 0;
    int     n_items = 0, n_results = 0, n_frames = 0;
    logic   quiet = 1'b0;
    logic   hold_req = 1'b0;

    // floor of 10^(k/10); terms above 2^31 go through a 64-bit integer
    function automatic logic [31:0] airtime_energy(logic signed [7:0] r);
        int  k;
        real v;
        k = int'(r) + 100;
        if (k < 0) return 32'd0;
        if (k > 96) return SCORE_CAP;
        v = (10.0 ** ((k % 10) / 10.0)) * (10.0 ** (k / 10));
        return 32'(longint'($floor(v)));
    endfunction

    function automatic t_stats channel_stats(logic [3:0] c);
        t_stats s;
        s = '0;
        s.ch = c;
        if (c >= 1 && c <= NCH) begin
            s.cnt = counts[c];
            s.pk  = (counts[c] != 0) ? peaks[c] : 8'sd0;
            s.sc  = scores[c];
        end
        return s;
    endfunction

    // apply one accepted item; returns 1 when it yields a result
    function automatic bit survey_update(output t_stats s);
        logic [31:0] term;
        logic [3:0]  best;
        bit          own;
        s = '0;
        case (t_action'(i_action))
            ACT_FRAME: begin
                own = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (node_ok[i] && node_addr[i] == i_tx_addr) own = 1;
                if (tuned >= 1 && tuned <= NCH && !(i_has_tx_addr && own)) begin
                    if (counts[tuned] != COUNT_MAX) counts[tuned]++;
                    if (counts[tuned] == 1 || i_rssi > peaks[tuned]) peaks[tuned] = i_rssi;
                    term = airtime_energy(i_rssi);
                    if (scores[tuned] < SCORE_CAP - term) scores[tuned] += term;
                end
                return 0;
            end
            ACT_TUNE: begin
                tuned = i_channel;
                return 0;
            end
            ACT_CLEAR: begin
                for (int c = 1; c <= NCH; c++) begin
                    counts[c] = '0;
                    peaks[c] = '0;
                    scores[c] = '0;
                end
                return 0;
            end
            ACT_CHOOSE: begin
                best = 4'd1;
                for (int c = 2; c <= NCH; c++)
                    if (scores[c] < scores[best]) best = 4'(c);
                s = channel_stats(best);
                return 1;
            end
            ACT_REPORT: begin
                s = channel_stats(i_channel);
                return 1;
            end
            ACT_NODE: begin
                node_addr[i_node_slot] = i_node_address;
                node_ok[i_node_slot] = i_node_in_use;
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_stats s, want;
        if (i_rst_n && i_valid && o_ready) begin
            n_items++;
            if (t_action'(i_action) == ACT_FRAME) n_frames++;
            if (survey_update(s)) stats_due.push_back(pin_on ? pin_res : s);
        end
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (stats_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result ch=%0d", o_chosen_channel);
            end else begin
                want = stats_due.pop_front();
                if (o_chosen_channel !== want.ch || o_frame_count !== want.cnt ||
                    o_strongest_rssi !== want.pk || o_energy_score !== want.sc) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp ch=%0d cnt=%0d pk=%0d sc=%0d, got ch=%0d cnt=%0d pk=%0d sc=%0d",
                                 want.ch, want.cnt, want.pk, want.sc, o_chosen_channel,
                                 o_frame_count, o_strongest_rssi, o_energy_score);
                end
            end
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                hold = 300;
                while (hold > 0) begin
                    @(negedge i_clk);
                    hold--;
                end
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            i_ready = 1'b1;
        end
    end

    // offer one item; returns at the falling edge after acceptance
    task automatic offer(t_row r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_action = r.act;
        i_rssi = r.rssi;
        i_has_tx_addr = r.has;
        i_tx_addr = r.tx;
        i_channel = r.ch;
        i_node_slot = r.slot;
        i_node_address = r.addr;
        i_node_in_use = r.use_it;
        pin_on = r.pinned;
        pin_res = r.res;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic t_row row(t_action a, logic signed [7:0] rs, logic h, logic [47:0] tx,
                                 logic [3:0] c, logic [2:0] sl, logic [47:0] ad, logic u);
        t_row r;
        r.act = a; r.rssi = rs; r.has = h; r.tx = tx; r.ch = c;
        r.slot = sl; r.addr = ad; r.use_it = u; r.pinned = 0; r.res = '0;
        return r;
    endfunction

    function automatic t_row pinned(t_row r, logic [3:0] c);
        r.pinned = 1;
        r.res = '{ch: c, cnt: 16'd0, pk: 8'sd0, sc: 32'd0};
        return r;
    endfunction

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_row        plan[$];
        t_row        r;
        logic [47:0] ones, own_addr;
        int          pick, wait_cnt;
        ones = '1;
        own_addr = 48'h0200_1122_3344;
        tuned = '0;
        for (int c = 1; c <= NCH; c++) begin
            counts[c] = '0; peaks[c] = '0; scores[c] = '0;
        end
        for (int i = 0; i < NSLOT; i++) begin
            node_addr[i] = '0; node_ok[i] = 0;
        end

        // directed rows: empty stats, edges of the fields, each action
        plan.push_back(pinned(row(ACT_REPORT, 0, 0, 0, 4'd1, 0, 0, 0), 4'd1));
        plan.push_back(pinned(row(ACT_CHOOSE, 0, 0, 0, 0, 0, 0, 0), 4'd1));
        plan.push_back(pinned(row(ACT_REPORT, 0, 0, 0, 4'd0, 0, 0, 0), 4'd0));
        plan.push_back(pinned(row(ACT_REPORT, 0, 0, 0, 4'd15, 0, 0, 0), 4'd15));
        plan.push_back(row(ACT_FRAME, 127, 0, 0, 0, 0, 0, 0));          // not tuned yet
        plan.push_back(row(ACT_TUNE, 0, 0, 0, 4'd15, 0, 0, 0));        // out of range
        plan.push_back(row(ACT_FRAME, -1, 1, ones, 0, 0, 0, 0));
        plan.push_back(row(ACT_TUNE, 0, 0, 0, 4'd1, 0, 0, 0));
        plan.push_back(row(ACT_FRAME, -128, 1, ones, 0, 0, 0, 0));     // first frame, no energy
        plan.push_back(row(ACT_FRAME, 127, 0, 0, 0, 0, 0, 0));          // capped term skips
        plan.push_back(row(ACT_FRAME, -100, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(ACT_FRAME, -4, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(ACT_FRAME, -50, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(ACT_REPORT, 0, 0, 0, 4'd1, 0, 0, 0));
        plan.push_back(row(ACT_NODE, 0, 0, 0, 0, 3'd7, ones, 1));
        plan.push_back(row(ACT_FRAME, 10, 1, ones, 0, 0, 0, 0));       // own node, dropped
        plan.push_back(row(ACT_FRAME, 10, 0, ones, 0, 0, 0, 0));       // no address, counted
        plan.push_back(row(ACT_NODE, 0, 0, 0, 0, 3'd0, 48'd0, 0));
        plan.push_back(row(ACT_TUNE, 0, 0, 0, 4'd13, 0, 0, 0));
        plan.push_back(row(ACT_FRAME, -20, 1, 48'd0, 0, 0, 0, 0));     // unused entry's address, counted
        plan.push_back(row(ACT_REPORT, 0, 0, 0, 4'd13, 0, 0, 0));
        plan.push_back(row(ACT_CHOOSE, 0, 0, 0, 0, 0, 0, 0));           // tie among empty
        plan.push_back(row(ACT_NOP6, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(ACT_NOP7, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(pinned(row(ACT_CHOOSE, 0, 0, 0, 0, 0, 0, 0), 4'd1));

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (plan[i]) offer(plan[i]);

        // random traffic, mostly frames on tuned channels
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) hold_req = 1'b1;
            if (n == RANDOM_ITEMS - 150) quiet = 1'b1;
            r = row(ACT_FRAME, 8'($urandom), 1'($urandom), {$urandom, 16'($urandom)},
                    4'($urandom), 3'($urandom), {$urandom, 16'($urandom)}, 1'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                r.act = ACT_FRAME;
                if ($urandom_range(0, 2) == 0) r.tx = own_addr;
                if ($urandom_range(0, 2) == 0) r.rssi = 8'($urandom_range(0, 30)) - 8'sd30;
            end else if (pick < 70) begin
                r.act = ACT_TUNE;
                if ($urandom_range(0, 5) != 0) r.ch = 4'($urandom_range(1, NCH));
            end else if (pick < 82) r.act = ACT_REPORT;
            else if (pick < 89) r.act = ACT_CHOOSE;
            else if (pick < 95) begin
                r.act = ACT_NODE;
                if ($urandom_range(0, 1) == 0) r.addr = own_addr;
            end else if (pick < 97) r.act = ACT_CLEAR;
            else r.act = $urandom_range(0, 1) ? ACT_NOP6 : ACT_NOP7;
            offer(r);
        end
        i_valid = 1'b0;

        wait_cnt = 0;
        while (stats_due.size() != 0 && wait_cnt < 100_000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (40) @(posedge i_clk);
        if (stats_due.size() != 0) errors++;
        $display("survey run: %0d items (%0d frames), %0d results checked, %0d mismatches",
                 n_items, n_frames, n_results, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- channel_airtime_survey.f -----
sv/cas_pkg.sv
sv/cas_front.sv
sv/cas_queue.sv
sv/cas_back.sv
sv/channel_airtime_survey.sv
test/channel_airtime_survey_tb.sv
